// ----- hdl/vat2d_pkg.sv -----
// ----------------------------------------------------------------------------
// vat2d_pkg
// Shared types and constants for the 2D affine vertex transform.
// ----------------------------------------------------------------------------
package vat2d_pkg;

  // transform selected by the mode register
  typedef enum logic [3:0] {
    MODE_TRANSLATE = 4'd0,
    MODE_ROTATE    = 4'd1,
    MODE_SCALE     = 4'd2,
    MODE_REFL_X    = 4'd3,
    MODE_REFL_Y    = 4'd4,
    MODE_ROT_PT    = 4'd5,
    MODE_SCALE_PT  = 4'd6,
    MODE_REFL_LINE = 4'd7,
    MODE_SHEAR     = 4'd8
  } mode_t;

  localparam int unsigned MODE_BITS = 4;
  localparam int unsigned REG_INDEX_BITS = 3;

  // configuration register map
  localparam logic [REG_INDEX_BITS-1:0] REG_MODE     = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_OFFSET_X = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_OFFSET_Y = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_COS = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_SIN = 3'd4;
  localparam logic [REG_INDEX_BITS-1:0] REG_FACTOR_X = 3'd5;
  localparam logic [REG_INDEX_BITS-1:0] REG_FACTOR_Y = 3'd6;

endpackage

// ----- hdl/vertex_affine_transform_2d.sv -----
// ----------------------------------------------------------------------------
// vertex_affine_transform_2d
// Six-stage pipelined 2D affine transform of streamed polygon vertices.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata: vertex_x, vertex_y
// m_axis    out  m_axis_tvalid/tready    tdata: result_x, result_y; tuser: saturated
// cfg       in   cfg_we                  cfg_index, cfg_data
//
// One vertex per cycle while the output is not stalled; each passes six register stages.
// The fixed depth comes from the line reflection: offset, multiply, truncate,
// multiply again, truncate, offset and saturate, one register stage each.
// rst clears the stage valid bits and loads the register reset values.
// A stalled output holds; empty stages still fill, so requests are taken
// while a result waits.
// ----------------------------------------------------------------------------
module vertex_affine_transform_2d #(
  parameter int unsigned COORD_BITS       = 16,
  parameter int unsigned TRIG_FRAC_BITS   = 14,
  parameter int unsigned FACTOR_FRAC_BITS = 8,
  localparam int unsigned IN_DW  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned TRIG_W = TRIG_FRAC_BITS + 2,
  localparam int unsigned FACT_W = 2 * FACTOR_FRAC_BITS,
  localparam int unsigned COEF_W = (TRIG_W > FACT_W) ? TRIG_W : FACT_W,
  localparam int unsigned CFG_W0 = (COORD_BITS > COEF_W) ? COORD_BITS : COEF_W,
  localparam int unsigned CFG_W  = CFG_W0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [COORD_BITS-1:0] vertex_x, [2*COORD_BITS-1:COORD_BITS] vertex_y
  input  logic [IN_DW-1:0]      s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [COORD_BITS-1:0] result_x, [2*COORD_BITS-1:COORD_BITS] result_y
  output logic [OUT_DW-1:0]     m_axis_tdata,
  // [0] saturated
  output logic                  m_axis_tuser,
  input  logic                  cfg_we,
  input  logic [vat2d_pkg::REG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int unsigned STAGE_BITS = 60 - COEF_W;
  // stage values: clamp bound or a negated input coordinate, whichever is wider
  localparam int unsigned SW0 = (STAGE_BITS > COORD_BITS + 1) ? STAGE_BITS : COORD_BITS + 1;
  localparam int unsigned SW  = SW0 + 1;
  localparam int unsigned CW  = COEF_W + 1;    // coefficient with room for negation
  localparam int unsigned PW  = SW + CW;       // product
  localparam int unsigned AW  = PW + 1;        // sum of two products

  localparam logic signed [AW-1:0] STAGE_LIM =
    {{(AW - STAGE_BITS){1'b0}}, {STAGE_BITS{1'b1}}};
  localparam logic signed [AW-1:0] STAGE_LIM_N = -STAGE_LIM;
  localparam logic signed [AW-1:0] MASK_T =
    {{(AW - TRIG_FRAC_BITS){1'b0}}, {TRIG_FRAC_BITS{1'b1}}};
  localparam logic signed [AW-1:0] MASK_F =
    {{(AW - FACTOR_FRAC_BITS){1'b0}}, {FACTOR_FRAC_BITS{1'b1}}};
  localparam logic signed [SW-1:0] OUT_HI =
    {{(SW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] OUT_LO = -OUT_HI - SW'(1);
  localparam logic signed [CW-1:0] FACT_ONE = CW'(1) << FACTOR_FRAC_BITS;

  // {clipped, value}
  function automatic logic [SW:0] clamp_stage(input logic signed [AW-1:0] v);
    logic [SW:0] r;
    if (v > STAGE_LIM) begin
      r = {1'b1, STAGE_LIM[SW-1:0]};
    end else if (v < STAGE_LIM_N) begin
      r = {1'b1, STAGE_LIM_N[SW-1:0]};
    end else begin
      r = {1'b0, v[SW-1:0]};
    end
    return r;
  endfunction

  // divide by 2^T or 2^F, rounding toward zero
  function automatic logic signed [AW-1:0] trunc_div(input logic signed [AW-1:0] v,
                                                      input logic by_trig);
    logic signed [AW-1:0] rt;
    logic signed [AW-1:0] rf;
    rt = $signed(v + (v[AW-1] ? MASK_T : '0)) >>> TRIG_FRAC_BITS;
    rf = $signed(v + (v[AW-1] ? MASK_F : '0)) >>> FACTOR_FRAC_BITS;
    return by_trig ? rt : rf;
  endfunction

  // {clipped, value}
  function automatic logic [COORD_BITS:0] sat_out(input logic signed [SW-1:0] v);
    logic [COORD_BITS:0] r;
    if (v > OUT_HI) begin
      r = {1'b1, OUT_HI[COORD_BITS-1:0]};
    end else if (v < OUT_LO) begin
      r = {1'b1, OUT_LO[COORD_BITS-1:0]};
    end else begin
      r = {1'b0, v[COORD_BITS-1:0]};
    end
    return r;
  endfunction

  // configuration registers
  logic        [vat2d_pkg::MODE_BITS-1:0] mode;
  logic signed [COORD_BITS-1:0]           offset_x;
  logic signed [COORD_BITS-1:0]           offset_y;
  logic signed [TRIG_W-1:0]               coef_cos;
  logic signed [TRIG_W-1:0]               coef_sin;
  logic signed [FACT_W-1:0]               factor_x;
  logic signed [FACT_W-1:0]               factor_y;

  vat2d_pkg::mode_t mode_e;
  logic             use_mult;
  logic             use_trig;
  logic             is_line;
  logic             is_about_pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= vat2d_pkg::MODE_TRANSLATE;
      offset_x <= '0;
      offset_y <= '0;
      coef_cos <= TRIG_W'(1) << TRIG_FRAC_BITS;
      coef_sin <= '0;
      factor_x <= FACT_W'(1) << FACTOR_FRAC_BITS;
      factor_y <= FACT_W'(1) << FACTOR_FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        vat2d_pkg::REG_MODE:     mode     <= cfg_data[vat2d_pkg::MODE_BITS-1:0];
        vat2d_pkg::REG_OFFSET_X: offset_x <= cfg_data[COORD_BITS-1:0];
        vat2d_pkg::REG_OFFSET_Y: offset_y <= cfg_data[COORD_BITS-1:0];
        vat2d_pkg::REG_COEF_COS: coef_cos <= cfg_data[TRIG_W-1:0];
        vat2d_pkg::REG_COEF_SIN: coef_sin <= cfg_data[TRIG_W-1:0];
        vat2d_pkg::REG_FACTOR_X: factor_x <= cfg_data[FACT_W-1:0];
        vat2d_pkg::REG_FACTOR_Y: factor_y <= cfg_data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // the user must change registers only while the pipe is empty (not enforced here); every stage reads them live
  assign mode_e      = vat2d_pkg::mode_t'(mode);
  assign use_mult    = mode_e inside {vat2d_pkg::MODE_ROTATE, vat2d_pkg::MODE_SCALE,
                                      vat2d_pkg::MODE_ROT_PT, vat2d_pkg::MODE_SCALE_PT,
                                      vat2d_pkg::MODE_REFL_LINE, vat2d_pkg::MODE_SHEAR};
  assign use_trig    = mode_e inside {vat2d_pkg::MODE_ROTATE, vat2d_pkg::MODE_ROT_PT,
                                      vat2d_pkg::MODE_REFL_LINE};
  assign is_line     = (mode_e == vat2d_pkg::MODE_REFL_LINE);
  assign is_about_pt = mode_e inside {vat2d_pkg::MODE_ROT_PT, vat2d_pkg::MODE_SCALE_PT};

  // pipeline flow: a stage loads when it is empty or the next one loads
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6 || m_axis_tready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // ---------------- stage 1: pre-offset and axis reflections ----------------
  logic signed [SW-1:0] in_x, in_y, ox, oy;
  logic        [SW:0]   add_x, add_y, sub_x, sub_y;
  logic signed [SW-1:0] x1_next, y1_next;
  logic                 clip1_next;
  logic signed [SW-1:0] x1, y1;
  logic                 clip1;

  always_comb begin
    in_x = SW'($signed(s_axis_tdata[COORD_BITS-1:0]));
    in_y = SW'($signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
    ox   = SW'(offset_x);
    oy   = SW'(offset_y);
    add_x = clamp_stage(AW'(in_x) + AW'(ox));
    add_y = clamp_stage(AW'(in_y) + AW'(oy));
    sub_x = clamp_stage(AW'(in_x) - AW'(ox));
    sub_y = clamp_stage(AW'(in_y) - AW'(oy));
    x1_next    = in_x;
    y1_next    = in_y;
    clip1_next = 1'b0;
    case (mode_e)
      vat2d_pkg::MODE_TRANSLATE: begin
        x1_next    = add_x[SW-1:0];
        y1_next    = add_y[SW-1:0];
        clip1_next = add_x[SW] | add_y[SW];
      end
      vat2d_pkg::MODE_REFL_X: y1_next = -in_y;
      vat2d_pkg::MODE_REFL_Y: x1_next = -in_x;
      vat2d_pkg::MODE_ROT_PT, vat2d_pkg::MODE_SCALE_PT: begin
        x1_next    = sub_x[SW-1:0];
        y1_next    = sub_y[SW-1:0];
        clip1_next = sub_x[SW] | sub_y[SW];
      end
      vat2d_pkg::MODE_REFL_LINE: begin
        y1_next    = sub_y[SW-1:0];
        clip1_next = sub_y[SW];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x1    <= x1_next;
      y1    <= y1_next;
      clip1 <= clip1_next;
    end
  end

  // ---------------- stage 2: first products ----------------
  // new x = (pa - pb) / 2^k, new y = (pc + pd) / 2^k, rounded toward zero
  logic signed [CW-1:0] c_ext, s_ext, fx_ext, fy_ext;
  logic signed [CW-1:0] ca, cb, cc, cd;
  logic signed [PW-1:0] pa, pb, pc, pd;
  logic signed [SW-1:0] x2, y2;
  logic                 clip2;

  always_comb begin
    c_ext  = CW'(coef_cos);
    s_ext  = CW'(coef_sin);
    fx_ext = CW'(factor_x);
    fy_ext = CW'(factor_y);
    ca = c_ext;
    cb = s_ext;
    cc = s_ext;
    cd = c_ext;
    case (mode_e)
      vat2d_pkg::MODE_SCALE, vat2d_pkg::MODE_SCALE_PT: begin
        ca = fx_ext;
        cb = '0;
        cc = '0;
        cd = fy_ext;
      end
      vat2d_pkg::MODE_REFL_LINE: begin
        // rotate by minus theta first
        cb = -s_ext;
        cc = -s_ext;
      end
      vat2d_pkg::MODE_SHEAR: begin
        ca = FACT_ONE;
        cb = -fx_ext;
        cc = fy_ext;
        cd = FACT_ONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pa    <= x1 * ca;
      pb    <= y1 * cb;
      pc    <= x1 * cc;
      pd    <= y1 * cd;
      x2    <= x1;
      y2    <= y1;
      clip2 <= clip1;
    end
  end

  // ---------------- stage 3: truncate and clamp ----------------
  logic        [SW:0]   nx2, ny2;
  logic signed [SW-1:0] x3_next, y3_next;
  logic                 clip3_next;
  logic signed [SW-1:0] x3, y3;
  logic                 clip3;

  always_comb begin
    nx2 = clamp_stage(trunc_div(AW'(pa) - AW'(pb), use_trig));
    ny2 = clamp_stage(trunc_div(AW'(pc) + AW'(pd), use_trig));
    if (use_mult) begin
      x3_next    = nx2[SW-1:0];
      y3_next    = is_line ? -$signed(ny2[SW-1:0]) : $signed(ny2[SW-1:0]);
      clip3_next = clip2 | nx2[SW] | ny2[SW];
    end else begin
      x3_next    = x2;
      y3_next    = y2;
      clip3_next = clip2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      x3    <= x3_next;
      y3    <= y3_next;
      clip3 <= clip3_next;
    end
  end

  // ---------------- stage 4: second rotation products (line reflection) ----
  logic signed [PW-1:0] qa, qb, qc, qd;
  logic signed [SW-1:0] x4, y4;
  logic                 clip4;

  always_ff @(posedge clk) begin
    if (en4) begin
      qa    <= x3 * c_ext;
      qb    <= y3 * s_ext;
      qc    <= x3 * s_ext;
      qd    <= y3 * c_ext;
      x4    <= x3;
      y4    <= y3;
      clip4 <= clip3;
    end
  end

  // ---------------- stage 5: truncate and clamp ----------------
  logic        [SW:0]   nx4, ny4;
  logic signed [SW-1:0] x5, y5;
  logic                 clip5;

  always_comb begin
    nx4 = clamp_stage(trunc_div(AW'(qa) - AW'(qb), 1'b1));
    ny4 = clamp_stage(trunc_div(AW'(qc) + AW'(qd), 1'b1));
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      if (is_line) begin
        x5    <= nx4[SW-1:0];
        y5    <= ny4[SW-1:0];
        clip5 <= clip4 | nx4[SW] | ny4[SW];
      end else begin
        x5    <= x4;
        y5    <= y4;
        clip5 <= clip4;
      end
    end
  end

  // ---------------- stage 6: post-offset, saturate, output register ----------
  logic        [SW:0]         px, py;
  logic signed [SW-1:0]       fx5, fy5;
  logic                       fclip;
  logic        [COORD_BITS:0] sx, sy;
  logic        [COORD_BITS-1:0] res_x, res_y;
  logic                       res_sat;

  always_comb begin
    px = clamp_stage(AW'(x5) + AW'(ox));
    py = clamp_stage(AW'(y5) + AW'(oy));
    fx5   = x5;
    fy5   = y5;
    fclip = clip5;
    if (is_about_pt) begin
      fx5   = px[SW-1:0];
      fy5   = py[SW-1:0];
      fclip = clip5 | px[SW] | py[SW];
    end else if (is_line) begin
      fy5   = py[SW-1:0];
      fclip = clip5 | py[SW];
    end
    sx = sat_out(fx5);
    sy = sat_out(fy5);
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      res_x   <= sx[COORD_BITS-1:0];
      res_y   <= sy[COORD_BITS-1:0];
      res_sat <= fclip | sx[COORD_BITS] | sy[COORD_BITS];
    end
  end

  assign m_axis_tvalid = v6;
  assign m_axis_tdata  = OUT_DW'({res_y, res_x});
  assign m_axis_tuser  = res_sat;

  // ---------------- checks ----------------
  // input is only ever held back by a stalled, full output
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // an empty output register always lets a request in
  a_empty_open: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused with output empty");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // a result reaching the output needs an item in the stage before it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(v6) |-> $past(v5))
    else $error("result appeared without an item behind it");

endmodule

// ----- tb/vertex_affine_transform_2d_tb.sv -----
// ----------------------------------------------------------------------------
// vertex_affine_transform_2d_tb
// Streams vertices through every transform mode and compares each result
// with a cycle-free fixed-point predictor held in the bench. Registers are
// reprogrammed between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
module vertex_affine_transform_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT_NS   = 8_000_000;
  localparam int          RANDOM_ITEMS   = 950;
  localparam int          STAGE_BITS     = 44;
  localparam longint      STAGE_LIM      = (64'sd1 <<< STAGE_BITS) - 64'sd1;
  localparam longint      FACTOR_ONE     = 64'sd256;
  localparam real         PI             = 3.14159265358979;
  localparam logic [vat2d_pkg::REG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
  localparam logic [vat2d_pkg::MODE_BITS-1:0] MODE_UNDEF_LO = 4'd9;
  localparam logic [vat2d_pkg::MODE_BITS-1:0] MODE_UNDEF_HI = 4'd15;

  typedef struct {
    logic [vat2d_pkg::MODE_BITS-1:0] mode_sel;
    logic signed [15:0]   off_x;
    logic signed [15:0]   off_y;
    logic signed [15:0]   cos_q;
    logic signed [15:0]   sin_q;
    logic signed [15:0]   fac_x;
    logic signed [15:0]   fac_y;
  } xform_regs_t;

  typedef struct {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic               sat;
  } vertex_result_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_BLOCKS} sink_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [15:0] vertex_x, [31:16] vertex_y
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] result_x, [31:16] result_y
  logic [31:0] m_axis_tdata;
  // [0] saturated
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [vat2d_pkg::REG_INDEX_BITS-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  xform_regs_t    regs_now;
  vertex_result_t pending_results[$];
  int             mismatch_count = 0;
  int             burst_left = 0;
  bit             sender_steady = 1'b0;
  bit             stage_clip;
  logic [5:0]     sink_tick = '0;
  sink_style_t    sink_style = SINK_OPEN;

  vertex_affine_transform_2d u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint bound_stage(longint v);
    if (v > STAGE_LIM) begin
      stage_clip = 1'b1;
      return STAGE_LIM;
    end
    if (v < -STAGE_LIM) begin
      stage_clip = 1'b1;
      return -STAGE_LIM;
    end
    return v;
  endfunction

  // drop fraction bits, rounding toward zero
  function automatic longint shift_toward_zero(longint v, int k);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = mag >>> k;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic void rotate_q14(inout longint x, inout longint y,
                                     input longint c, input longint s);
    longint nx, ny;
    nx = shift_toward_zero(x * c - y * s, 14);
    ny = shift_toward_zero(x * s + y * c, 14);
    x = bound_stage(nx);
    y = bound_stage(ny);
  endfunction

  function automatic void scale_q8(inout longint x, inout longint y,
                                   input longint fx, input longint fy);
    x = bound_stage(shift_toward_zero(x * fx, 8));
    y = bound_stage(shift_toward_zero(y * fy, 8));
  endfunction

  function automatic logic signed [15:0] clip_coord(longint v);
    if (v > 32767) begin
      stage_clip = 1'b1;
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      stage_clip = 1'b1;
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  function automatic vertex_result_t predict_vertex(logic signed [15:0] vx,
                                                    logic signed [15:0] vy);
    longint x, y, ox, oy, c, s, fx, fy, nx;
    vertex_result_t r;
    x  = vx;
    y  = vy;
    ox = regs_now.off_x;
    oy = regs_now.off_y;
    c  = regs_now.cos_q;
    s  = regs_now.sin_q;
    fx = regs_now.fac_x;
    fy = regs_now.fac_y;
    stage_clip = 1'b0;
    case (regs_now.mode_sel)
      vat2d_pkg::MODE_TRANSLATE: begin
        x = bound_stage(x + ox);
        y = bound_stage(y + oy);
      end
      vat2d_pkg::MODE_ROTATE: rotate_q14(x, y, c, s);
      vat2d_pkg::MODE_SCALE:  scale_q8(x, y, fx, fy);
      vat2d_pkg::MODE_REFL_X: y = -y;
      vat2d_pkg::MODE_REFL_Y: x = -x;
      vat2d_pkg::MODE_ROT_PT, vat2d_pkg::MODE_SCALE_PT: begin
        x = bound_stage(x - ox);
        y = bound_stage(y - oy);
        if (regs_now.mode_sel == vat2d_pkg::MODE_ROT_PT) rotate_q14(x, y, c, s);
        else scale_q8(x, y, fx, fy);
        x = bound_stage(x + ox);
        y = bound_stage(y + oy);
      end
      vat2d_pkg::MODE_REFL_LINE: begin
        // shift line to origin, turn it onto the x axis, mirror, turn back
        y = bound_stage(y - oy);
        rotate_q14(x, y, c, -s);
        y = -y;
        rotate_q14(x, y, c, s);
        y = bound_stage(y + oy);
      end
      vat2d_pkg::MODE_SHEAR: begin
        nx = bound_stage(shift_toward_zero(x * FACTOR_ONE + y * fx, 8));
        y  = bound_stage(shift_toward_zero(y * FACTOR_ONE + x * fy, 8));
        x  = nx;
      end
      default: ;
    endcase
    r.rx  = clip_coord(x);
    r.ry  = clip_coord(y);
    r.sat = stage_clip;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [15:0] edge_value();
    case ($urandom_range(0, 8))
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd16384;
      6:       return -16'sd16384;
      7:       return 16'sd256;
      default: return 16'sh7FFF;
    endcase
  endfunction

  function automatic logic signed [15:0] random_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return edge_value();
    if (pick <= 2) return 16'(int'($urandom_range(0, 400)) - 200);
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] random_factor();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 16'(int'($urandom_range(0, 2048)) - 1024);
    if (pick < 8) return edge_value();
    return 16'($urandom);
  endfunction

  function automatic xform_regs_t random_regs();
    xform_regs_t r;
    real ang;
    int pick;
    if ($urandom_range(0, 9) == 0) r.mode_sel = 4'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
    else r.mode_sel = 4'($urandom_range(vat2d_pkg::MODE_TRANSLATE, vat2d_pkg::MODE_SHEAR));
    r.off_x = random_coord();
    r.off_y = random_coord();
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      ang = $urandom_range(0, 3599) * PI / 1800.0;
      r.cos_q = 16'($rtoi($cos(ang) * 16384.0));
      r.sin_q = 16'($rtoi($sin(ang) * 16384.0));
    end else if (pick < 9) begin
      r.cos_q = edge_value();
      r.sin_q = edge_value();
    end else begin
      r.cos_q = 16'($urandom);
      r.sin_q = 16'($urandom);
    end
    r.fac_x = random_factor();
    r.fac_y = random_factor();
    return r;
  endfunction

  function automatic xform_regs_t make_regs(logic [vat2d_pkg::MODE_BITS-1:0] m,
                                            logic signed [15:0] ox, oy, c, s, fx, fy);
    xform_regs_t r;
    r.mode_sel = m;
    r.off_x = ox;
    r.off_y = oy;
    r.cos_q = c;
    r.sin_q = s;
    r.fac_x = fx;
    r.fac_y = fy;
    return r;
  endfunction

  // wait until every request has produced its result
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // whole register set, junk in the spare mode bits and the unused index
  task automatic reconfigure(input xform_regs_t r);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= vat2d_pkg::REG_MODE;
    cfg_data  <= {12'($urandom), r.mode_sel};
    @(posedge clk);
    cfg_index <= vat2d_pkg::REG_OFFSET_X;
    cfg_data  <= r.off_x;
    @(posedge clk);
    cfg_index <= vat2d_pkg::REG_OFFSET_Y;
    cfg_data  <= r.off_y;
    @(posedge clk);
    cfg_index <= vat2d_pkg::REG_COEF_COS;
    cfg_data  <= r.cos_q;
    @(posedge clk);
    cfg_index <= vat2d_pkg::REG_COEF_SIN;
    cfg_data  <= r.sin_q;
    @(posedge clk);
    cfg_index <= vat2d_pkg::REG_FACTOR_X;
    cfg_data  <= r.fac_x;
    @(posedge clk);
    cfg_index <= vat2d_pkg::REG_FACTOR_Y;
    cfg_data  <= r.fac_y;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    regs_now = r;
  endtask

  task automatic send_vertex(input logic signed [15:0] vx, input logic signed [15:0] vy);
    int gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {vy, vx};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), predict_vertex(vx, vy));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_vertex(16'sh7FFF, 16'sh8000);
    send_vertex(-16'sd1, 16'sd1);
  endtask

  task automatic test_translate();
    reconfigure(make_regs(vat2d_pkg::MODE_TRANSLATE, 16'sh7FFF, 16'sh8000, 16'sd16384,
                          16'sd0, 16'sd256, 16'sd256));
    send_vertex(16'sh7FFF, 16'sh8000);
    send_vertex(16'sh8000, 16'sh7FFF);
  endtask

  task automatic test_rotate();
    // 45 degrees: exposes truncation of negative products
    reconfigure(make_regs(vat2d_pkg::MODE_ROTATE, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585,
                          16'sd256, 16'sd256));
    send_vertex(16'sd100, -16'sd200);
    send_vertex(16'sh8000, 16'sh8000);
    send_vertex(16'sh7FFF, 16'sh8000);
  endtask

  task automatic test_scale();
    reconfigure(make_regs(vat2d_pkg::MODE_SCALE, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                          16'sh8000, 16'sh7FFF));
    send_vertex(16'sh8000, 16'sh7FFF);
    send_vertex(16'sd3, -16'sd3);
  endtask

  task automatic test_reflect_axes();
    // negating the most negative coordinate must clip
    reconfigure(make_regs(vat2d_pkg::MODE_REFL_X, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                          16'sd256, 16'sd256));
    send_vertex(16'sd5, 16'sh8000);
    send_vertex(16'sh8000, 16'sh7FFF);
    reconfigure(make_regs(vat2d_pkg::MODE_REFL_Y, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                          16'sd256, 16'sd256));
    send_vertex(16'sh8000, 16'sd7);
    send_vertex(16'sh7FFF, -16'sd1);
  endtask

  task automatic test_rotate_about_point();
    reconfigure(make_regs(vat2d_pkg::MODE_ROT_PT, 16'sd1000, -16'sd1000, 16'sd0,
                          -16'sd16384, 16'sd256, 16'sd256));
    send_vertex(16'sh7FFF, 16'sh7FFF);
    send_vertex(16'sd1000, -16'sd1000);
  endtask

  task automatic test_scale_about_point();
    reconfigure(make_regs(vat2d_pkg::MODE_SCALE_PT, 16'sh8000, 16'sh7FFF, 16'sd16384,
                          16'sd0, 16'sd512, 16'sd128));
    send_vertex(16'sd0, 16'sd0);
    send_vertex(16'sh7FFF, 16'sh8000);
  endtask

  task automatic test_reflect_line();
    // line y = x + 50
    reconfigure(make_regs(vat2d_pkg::MODE_REFL_LINE, 16'sd0, 16'sd50, 16'sd11585,
                          16'sd11585, 16'sd256, 16'sd256));
    send_vertex(16'sd100, 16'sd30);
    send_vertex(16'sh8000, 16'sh7FFF);
  endtask

  task automatic test_shear();
    reconfigure(make_regs(vat2d_pkg::MODE_SHEAR, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                          16'sh7FFF, 16'sh8000));
    send_vertex(16'sh7FFF, 16'sh7FFF);
    send_vertex(-16'sd1, 16'sd1);
  endtask

  task automatic test_undefined_mode();
    reconfigure(make_regs(MODE_UNDEF_HI, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF,
                          16'sh8000, 16'sh7FFF));
    send_vertex(16'sh7FFF, 16'sh8000);
    reconfigure(make_regs(MODE_UNDEF_LO, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_vertex(-16'sd1, 16'sd0);
  endtask

  task automatic test_random_mix();
    int sent, phase_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      reconfigure(random_regs());
      sender_steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 70);
      repeat (phase_len) send_vertex(random_coord(), random_coord());
      sent += phase_len;
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string what, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    vertex_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unrequested result: expected none, got x=%0d y=%0d sat=%0b",
                 $time, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                 m_axis_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_x", want.rx, m_axis_tdata[15:0]);
        check_field("result_y", want.ry, m_axis_tdata[31:16]);
        check_field("saturated", {15'd0, want.sat}, {15'd0, m_axis_tuser});
      end
    end
  end

  // receiver back-pressure, style changes each time the 6-bit tick counter wraps
  always @(posedge clk) begin
    sink_tick <= sink_tick + 6'd1;
    if (sink_tick == 6'd0) sink_style <= sink_style_t'($urandom_range(0, 3));
    case (sink_style)
      SINK_OPEN:   m_axis_tready <= 1'b1;
      SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      SINK_SPARSE: m_axis_tready <= (sink_tick[1:0] == 2'd0);
      default:     m_axis_tready <= sink_tick[4];
    endcase
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    regs_now = make_regs(vat2d_pkg::MODE_TRANSLATE, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                         16'sd256, 16'sd256);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_translate();
    test_rotate();
    test_scale();
    test_reflect_axes();
    test_rotate_about_point();
    test_scale_about_point();
    test_reflect_line();
    test_shear();
    test_undefined_mode();
    test_random_mix();
    settle();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
